// ===== rtl/bdq_pkg.sv =====
// Shared constants and codes for the bounded deque with odd filter.
`default_nettype none
package bdq_pkg;

  // Storage geometry.
  localparam int CAPACITY = 32;
  localparam int PTR_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Field widths of a request and a result.
  localparam int VALUE_W    = 32;
  localparam int OPCODE_W   = 3;
  localparam int COUNT_W    = 6;
  localparam int STATUS_W   = 2;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 40;

  // Operation codes.
  localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_DROP_EVENS = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_DUMP       = 3'd5;

  // Status codes.
  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

endpackage
`default_nettype wire

// ===== rtl/bounded_deque_with_odd_filter_top.sv =====
// Top level of the bounded deque with odd filter: sequencer, pointers and result register.
`default_nettype none
// Push and pop requests pass through the response state, which loads the result register
// when it is free and then returns the block to idle, where it takes the next request.
// Remove-evens walks the stored elements through the single memory read port, writing back
// only the odd ones. Dump reads each element and emits it before it reads the next one.
// A stalled result holds the response and dump-output states until the result drains.
// Reset (rst, synchronous, active high) empties the deque and drops the result valid.
module bounded_deque_with_odd_filter_top (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // Request channel.
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [bdq_pkg::IN_DATA_W-1:0]    s_tdata,   // [31:0] value
  input  wire logic [bdq_pkg::OPCODE_W-1:0]     s_tuser,   // [2:0] opcode
  // Result channel.
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic      [bdq_pkg::OUT_DATA_W-1:0]   m_tdata,   // [31:0] element, [37:32] count,
                                                           // [39:38] status
  output logic                                  m_tuser,   // [0] has_element
  output logic                                  m_tlast    // last result of a request
);

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;  // waiting for a request
  localparam logic [2:0] S_RESP = 3'd1;  // single status result pending
  localparam logic [2:0] S_FRD  = 3'd2;  // filter: read next element
  localparam logic [2:0] S_FWR  = 3'd3;  // filter: keep odd element
  localparam logic [2:0] S_DRD  = 3'd4;  // dump: read next element
  localparam logic [2:0] S_DOUT = 3'd5;  // dump: emit element

  localparam int SUM_W = bdq_pkg::CNT_W + 1;

  logic [2:0]                     state;
  logic [bdq_pkg::CNT_W-1:0]      count;
  logic [bdq_pkg::PTR_W-1:0]      front;
  logic [bdq_pkg::CNT_W-1:0]      idx;
  logic [bdq_pkg::CNT_W-1:0]      kept;
  logic [bdq_pkg::STATUS_W-1:0]   res_status;

  logic                           in_accept;
  logic                           out_free;
  logic                           full;
  logic                           empty;
  logic [bdq_pkg::CNT_W-1:0]      idx_inc;

  // The shared slot unit maps an offset from the front into a store address.
  // The offset is the count for push-back, the kept count while the filter
  // writes, and the walk index for every read.
  logic [bdq_pkg::CNT_W-1:0]      slot_off;
  logic [SUM_W-1:0]               slot_sum;
  logic [bdq_pkg::PTR_W-1:0]      slot_addr;
  logic [bdq_pkg::PTR_W-1:0]      front_dec;
  logic [bdq_pkg::PTR_W-1:0]      front_inc;

  logic                           mem_we;
  logic [bdq_pkg::PTR_W-1:0]      mem_waddr;
  logic [bdq_pkg::VALUE_W-1:0]    mem_wdata;
  logic                           mem_re;
  logic [bdq_pkg::VALUE_W-1:0]    mem_rdata;

  assign s_tready  = (state == S_IDLE);
  assign in_accept = s_tvalid && s_tready;
  // The result register can take a new result when empty or being drained.
  assign out_free  = !m_tvalid || m_tready;
  assign full      = (count >= bdq_pkg::CNT_W'(bdq_pkg::CAPACITY));
  assign empty     = (count == '0);
  assign idx_inc   = idx + bdq_pkg::CNT_W'(1);

  always_comb begin
    case (state)
      S_IDLE:  slot_off = count;
      S_FWR:   slot_off = kept;
      default: slot_off = idx;
    endcase
  end

  assign slot_sum  = SUM_W'(front) + SUM_W'(slot_off);
  assign slot_addr = (slot_sum >= SUM_W'(bdq_pkg::CAPACITY)) ?
                     bdq_pkg::PTR_W'(slot_sum - SUM_W'(bdq_pkg::CAPACITY)) :
                     bdq_pkg::PTR_W'(slot_sum);

  assign front_dec = (front == '0) ? bdq_pkg::PTR_W'(bdq_pkg::CAPACITY - 1) :
                     front - bdq_pkg::PTR_W'(1);
  assign front_inc = (front == bdq_pkg::PTR_W'(bdq_pkg::CAPACITY - 1)) ? '0 :
                     front + bdq_pkg::PTR_W'(1);

  // Store port control. Pushes write from the request; the filter writes back the
  // element it just read, which always lands at or behind the read position.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = slot_addr;
    mem_wdata = s_tdata;
    if (in_accept && !full && (s_tuser == bdq_pkg::OP_PUSH_BACK)) begin
      mem_we = 1'b1;
    end else if (in_accept && !full && (s_tuser == bdq_pkg::OP_PUSH_FRONT)) begin
      mem_we    = 1'b1;
      mem_waddr = front_dec;
    end else if ((state == S_FWR) && mem_rdata[0]) begin
      mem_we    = 1'b1;
      mem_wdata = mem_rdata;
    end
  end

  assign mem_re = ((state == S_FRD) && (idx != count)) || (state == S_DRD);

  bdq_store u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (slot_addr),
    .rdata (mem_rdata)
  );

  // Sequencer and deque pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      front      <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_accept) begin
            idx        <= '0;
            kept       <= '0;
            case (s_tuser)
              bdq_pkg::OP_PUSH_BACK: begin
                state <= S_RESP;
                if (full) begin
                  res_status <= bdq_pkg::STAT_FULL;
                end else begin
                  res_status <= bdq_pkg::STAT_OK;
                  count      <= count + bdq_pkg::CNT_W'(1);
                end
              end
              bdq_pkg::OP_PUSH_FRONT: begin
                state <= S_RESP;
                if (full) begin
                  res_status <= bdq_pkg::STAT_FULL;
                end else begin
                  res_status <= bdq_pkg::STAT_OK;
                  front      <= front_dec;
                  count      <= count + bdq_pkg::CNT_W'(1);
                end
              end
              bdq_pkg::OP_POP_FRONT: begin
                state <= S_RESP;
                if (empty) begin
                  res_status <= bdq_pkg::STAT_EMPTY;
                end else begin
                  res_status <= bdq_pkg::STAT_OK;
                  front      <= front_inc;
                  count      <= count - bdq_pkg::CNT_W'(1);
                end
              end
              bdq_pkg::OP_POP_BACK: begin
                state <= S_RESP;
                if (empty) begin
                  res_status <= bdq_pkg::STAT_EMPTY;
                end else begin
                  res_status <= bdq_pkg::STAT_OK;
                  count      <= count - bdq_pkg::CNT_W'(1);
                end
              end
              bdq_pkg::OP_DROP_EVENS: begin
                res_status <= bdq_pkg::STAT_OK;
                state      <= S_FRD;
              end
              bdq_pkg::OP_DUMP: begin
                // An empty dump gives the plain status result.
                res_status <= bdq_pkg::STAT_OK;
                state      <= empty ? S_RESP : S_DRD;
              end
              default: begin
                res_status <= bdq_pkg::STAT_OK;
                state      <= S_RESP;
              end
            endcase
          end
        end
        S_RESP: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        S_FRD: begin
          if (idx == count) begin
            count <= kept;
            state <= S_RESP;
          end else begin
            state <= S_FWR;
          end
        end
        S_FWR: begin
          if (mem_rdata[0]) begin
            kept <= kept + bdq_pkg::CNT_W'(1);
          end
          idx   <= idx_inc;
          state <= S_FRD;
        end
        S_DRD: begin
          state <= S_DOUT;
        end
        S_DOUT: begin
          if (out_free) begin
            idx   <= idx_inc;
            state <= (idx_inc == count) ? S_IDLE : S_DRD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Result register. Status results carry a zero element.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == S_RESP) && out_free) begin
      m_tvalid <= 1'b1;
      m_tdata  <= {res_status, bdq_pkg::COUNT_W'(count), {bdq_pkg::VALUE_W{1'b0}}};
      m_tuser  <= 1'b0;
      m_tlast  <= 1'b1;
    end else if ((state == S_DOUT) && out_free) begin
      m_tvalid <= 1'b1;
      m_tdata  <= {bdq_pkg::STAT_OK, bdq_pkg::COUNT_W'(count), mem_rdata};
      m_tuser  <= 1'b1;
      m_tlast  <= (idx_inc == count);
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/bdq_store.sv =====
// Element store: one write port and one read port with registered read data.
`default_nettype none
module bdq_store (
  input  wire logic                         clk,
  input  wire logic                         we,
  input  wire logic [bdq_pkg::PTR_W-1:0]    waddr,
  input  wire logic [bdq_pkg::VALUE_W-1:0]  wdata,
  input  wire logic                         re,
  input  wire logic [bdq_pkg::PTR_W-1:0]    raddr,
  output logic      [bdq_pkg::VALUE_W-1:0]  rdata
);

  logic [bdq_pkg::VALUE_W-1:0] mem [bdq_pkg::CAPACITY];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire
